// ===== rtl/snim_pkg.sv =====
// Shared constants and types for the sector number index map.
`default_nettype none
package snim_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int KEY_W      = 32;

  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the accepted input item, reset the scan
    logic scan;      // advance the key store scan by one step
    logic commit;    // apply the store update of add/remove
    logic out_load;  // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;  // incoming item must walk the key store
    logic scan_done;   // scan finished (all compared, or find hit)
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/snim_ctrl.sv =====
// Control state machine for the sector number index map.
`default_nettype none
module snim_ctrl
  import snim_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit   = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/snim_dp.sv =====
// Datapath: key store, valid marks, scan compare and output register.
`default_nettype none
module snim_dp
  import snim_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [KEY_W-1:0]  in_key,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [SLOT_W-1:0]      out_slot_found,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  logic [KEY_W-1:0]  key_mem [SLOT_COUNT];
  logic [KEY_W-1:0]  rdata_r;
  logic [SLOT_COUNT-1:0] valid_r;

  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  slot_r;
  logic              slot_ok_r;
  logic [KEY_W-1:0]  key_r;

  logic [CNT_W-1:0]  rd_cnt_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  found_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic in_slot_ok;
  logic issue;
  logic match;
  logic is_find;

  assign in_slot_ok = 32'(in_slot) < 32'(SLOT_COUNT);
  assign is_find    = (mode_r == MODE_FIND);
  assign issue      = cmd.scan && (rd_cnt_r != CNT_W'(SLOT_COUNT));
  assign match      = cmp_vld_r && valid_r[cmp_idx_r] && (rdata_r == key_r) && !hit_r;

  assign sts.needs_scan = (in_mode == MODE_FIND) || ((in_mode == MODE_ADD) && in_slot_ok);
  assign sts.scan_done  = (is_find && hit_r) ||
                          ((rd_cnt_r == CNT_W'(SLOT_COUNT)) && !cmp_vld_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      slot_r    <= IDX_W'(in_slot);
      slot_ok_r <= in_slot_ok;
      key_r     <= in_key;
    end
  end

  // key store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && (mode_r == MODE_ADD) && slot_ok_r) begin
      key_mem[slot_r] <= key_r;
    end
    if (issue) begin
      rdata_r <= key_mem[rd_cnt_r[IDX_W-1:0]];
    end
  end

  // scan sequencing; the compare stage works on the read data in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (match && is_find) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (cmd.load) begin
      found_r <= '0;
    end else if (match && is_find) begin
      found_r <= cmp_idx_r;
    end
  end

  // valid marks: add unlinks any slot holding the key, then links its slot; remove unlinks its slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (match && (mode_r == MODE_ADD)) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end
      if (cmd.commit && slot_ok_r) begin
        if (mode_r == MODE_ADD) begin
          valid_r[slot_r] <= 1'b1;
        end else if (mode_r == MODE_REMOVE) begin
          valid_r[slot_r] <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r  <= is_find && hit_r;
      out_slot_r <= (is_find && hit_r) ? SLOT_W'(found_r) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot_found = out_slot_r;

endmodule
`default_nettype wire

// ===== rtl/sector_number_index_map_core.sv =====
// Top level of the sector number index map: controller plus datapath.
`default_nettype none
// Sector number index map. Maps 32-bit sector numbers (keys) to buffer
// slots. Each input transfer carries a mode: find a key, add a slot under
// a key, or remove a slot; each gives exactly one result transfer (hit and
// slot_found, both zero unless a find hits). At most one slot holds a key:
// adding a key already held elsewhere unlinks the old slot. Keys live in a
// SLOT_COUNT-entry memory with one read port, so find and add walk it one
// entry per cycle; a find stops early when it hits, after the matching
// entry is compared, while remove, an add to an out-of-range slot or an
// unused mode skip the walk. The block handles one item at a time; in_ready
// is high only while idle. Results sit in an output register, so a new item
// is accepted while the previous result still waits for out_ready. Valid
// marks reset to empty at once; no clearing pass is needed.
module sector_number_index_map_core
  import snim_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [KEY_W-1:0]  in_key,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [SLOT_W-1:0]      out_slot_found
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: idle -> scan (find/add) -> done -> idle
  snim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // key memory, valid marks, compare and result register
  snim_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_slot        (in_slot),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_slot_found (out_slot_found),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

// ===== tb/snim_tb_pkg.sv =====
// Scoreboard for the sector number index map testbench: slot map predictor and result check.
package snim_tb_pkg;
  import snim_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot_found;
  } reply_t;

  class slot_map_scoreboard;
    bit               linked [SLOT_COUNT];
    logic [KEY_W-1:0] stored_key [SLOT_COUNT];
    reply_t           pending_replies [$];
    int               mismatches;

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Applies one request to the slot map copy and returns its reply.
    function reply_t map_lookup_update(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                       logic [KEY_W-1:0] key);
      reply_t r;
      r = '0;
      case (mode)
        MODE_FIND: begin
          // at most one linked slot holds a key; scan down so the lowest wins anyway
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (linked[i] && stored_key[i] == key) begin
              r.hit        = 1'b1;
              r.slot_found = SLOT_W'(i);
            end
          end
        end
        MODE_ADD: begin
          if (int'(slot) < SLOT_COUNT) begin
            linked[slot] = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (linked[i] && stored_key[i] == key) linked[i] = 1'b0;
            end
            stored_key[slot] = key;
            linked[slot]     = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (int'(slot) < SLOT_COUNT) linked[slot] = 1'b0;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                               logic [KEY_W-1:0] key);
      pending_replies.push_back(map_lookup_update(mode, slot, key));
    endfunction

    task check_reply(logic hit, logic [SLOT_W-1:0] slot_found);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result hit=%0b slot=%0d with nothing expected",
                                  hit, slot_found));
      end else begin
        exp = pending_replies.pop_front();
        if (hit !== exp.hit)
          report_mismatch($sformatf("hit: got %0b expected %0b", hit, exp.hit));
        if (slot_found !== exp.slot_found)
          report_mismatch($sformatf("slot_found: got %0d expected %0d",
                                    slot_found, exp.slot_found));
      end
    endtask

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_sector_number_index_map_core.sv =====
// Top of the sector number index map testbench: clock, reset, stimulus, receiver and checks.
module tb_sector_number_index_map_core;
  timeunit 1ns;
  timeprecision 1ps;

  import snim_pkg::*;
  import snim_tb_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_ITEMS   = 425;  // per phase, four phases
  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [KEY_W-1:0]  in_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot_found;

  slot_map_scoreboard sb;
  int                 idle_cycles = 0;
  int                 in_accepted = 0;
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  sector_number_index_map_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_slot        (in_slot),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_slot_found (out_slot_found)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: every edge, log accepted requests into the predictor first, then
  // check any accepted result against the oldest pending reply. Values sampled
  // here are the pre-edge ones, since all drivers use nonblocking updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_mode, in_slot, in_key);
        in_accepted <= in_accepted + 1;
      end
      if (out_valid && out_ready) sb.check_reply(out_hit, out_slot_found);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: nothing moved for too long.
  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("stall: no transfer for %0d cycles, %0d results pending",
             STALL_LIMIT, sb.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: out_ready follows a style picked per window of cycles. Twice it
  // holds off for HOLD_CYCLES so the result register fills and in_ready drops
  // while the sender keeps offering.
  initial begin
    int window;
    int style;
    int hold_left;
    int holds_done;
    window     = 0;
    style      = 0;
    hold_left  = 0;
    holds_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && in_accepted >= 500 + holds_done * 800) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
      end else begin
        case (style)
          0: out_ready <= 1'b1;                              // no stalls
          1: out_ready <= 1'($urandom_range(0, 1));          // coin flip
          2: out_ready <= ($urandom_range(0, 7) != 0);       // rare stall
          default: out_ready <= ((window % 7) >= 3);         // fixed stall pattern
        endcase
      end
      window++;
      if (window >= 150) begin
        window = 0;
        style  = $urandom_range(0, 3);
      end
      @(posedge clk);
    end
  end

  // Offer one request and hold it until the transfer. Entered right after an
  // edge; returns right after the accepting edge with in_valid still high.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                           input logic [KEY_W-1:0] key);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_slot  <= slot;
    in_key   <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits for an edge first so the monitor has logged the last accepted request.
  task automatic drain_results();
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Seed the key pool with extremes, single-byte neighbors (keys that differ
  // in one byte) and plain random keys.
  task automatic fill_key_pool();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) key_pool[i] = $urandom;
      else key_pool[i] = key_pool[i-1] ^ (32'hFF << (8 * $urandom_range(0, 3)));
    end
  endtask

  // One random phase. The pool span sets how often keys collide: a small span
  // forces replacements and hits, a wide one fills the store.
  task automatic run_random(input int count, input int span);
    int               sel;
    int               burst;
    int               gap;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    burst = $urandom_range(1, 40);
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      if (sel < 40) begin
        mode = MODE_FIND;
        if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, span - 1)];
        else key = $urandom;
      end else if (sel < 75) begin
        mode = MODE_ADD;
        if ($urandom_range(0, 4) < 3) begin
          key = key_pool[$urandom_range(0, span - 1)];
        end else begin
          key = $urandom;
          key_pool[$urandom_range(0, span - 1)] = key;
        end
      end else if (sel < 92) begin
        mode = MODE_REMOVE;
        key  = $urandom;
      end else begin
        mode = MODE_UNUSED;
        key  = $urandom;
      end
      send_item(mode, slot, key);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    int spans [4];
    spans[0] = 4;
    spans[1] = 16;
    spans[2] = 32;
    spans[3] = 8;
    sb = new;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, key and slot extremes, unused mode, re-add with
    // own key, key taken over by another slot, slot moved to a new key,
    // remove of an unlinked slot, near-miss key.
    send_item(MODE_FIND,   6'd0,  32'h0000_0000);
    send_item(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
    send_item(MODE_ADD,    6'd0,  32'h0000_0000);
    send_item(MODE_ADD,    6'd63, 32'hFFFF_FFFF);
    send_item(MODE_FIND,   6'd17, 32'h0000_0000);
    send_item(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send_item(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
    send_item(MODE_ADD,    6'd63, 32'hFFFF_FFFF);
    send_item(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
    send_item(MODE_ADD,    6'd5,  32'h0000_0000);
    send_item(MODE_FIND,   6'd0,  32'h0000_0000);
    send_item(MODE_ADD,    6'd5,  32'h1234_5678);
    send_item(MODE_FIND,   6'd0,  32'h0000_0000);
    send_item(MODE_FIND,   6'd0,  32'h1234_5678);
    send_item(MODE_REMOVE, 6'd0,  32'h0000_0000);
    send_item(MODE_REMOVE, 6'd5,  32'hFFFF_FFFF);
    send_item(MODE_FIND,   6'd5,  32'h1234_5678);
    send_item(MODE_ADD,    6'd42, 32'h8000_0000);
    send_item(MODE_FIND,   6'd0,  32'h8000_0001);
    send_item(MODE_FIND,   6'd0,  32'h8000_0000);
    send_item(MODE_REMOVE, 6'd63, 32'h0000_0000);
    send_item(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 6'd0,  32'h0000_0000);

    // Sender pauses until every directed result is back.
    in_valid <= 1'b0;
    drain_results();
    @(posedge clk);

    fill_key_pool();
    for (int p = 0; p < 4; p++) run_random(RAND_ITEMS, spans[p]);

    in_valid <= 1'b0;
    drain_results();
    // Let the block sit a while to catch any stray result transfer.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
